/* rtl/regex_source_escaper_defines.svh */
// Assertion macros shared by the escaper RTL.
`ifndef REGEX_SOURCE_ESCAPER_DEFINES_SVH
`define REGEX_SOURCE_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
`define RSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/rse_pkg.sv */
// Types, code-unit constants and expansion functions for the escaper.
package rse_pkg;

  localparam logic [15:0] U_BSLASH = 16'h005C;
  localparam logic [15:0] U_SLASH  = 16'h002F;
  localparam logic [15:0] U_LBRACK = 16'h005B;
  localparam logic [15:0] U_RBRACK = 16'h005D;
  localparam logic [15:0] U_LF     = 16'h000A;
  localparam logic [15:0] U_CR     = 16'h000D;
  localparam logic [15:0] U_LS     = 16'h2028;
  localparam logic [15:0] U_PS     = 16'h2029;
  localparam logic [15:0] U_N      = 16'h006E;
  localparam logic [15:0] U_R      = 16'h0072;
  localparam logic [15:0] U_U      = 16'h0075;
  localparam logic [15:0] U_TWO    = 16'h0032;
  localparam logic [15:0] U_ZERO   = 16'h0030;
  localparam logic [15:0] U_EIGHT  = 16'h0038;
  localparam logic [15:0] U_NINE   = 16'h0039;
  localparam logic [15:0] U_LPAREN = 16'h0028;
  localparam logic [15:0] U_QMARK  = 16'h003F;
  localparam logic [15:0] U_COLON  = 16'h003A;
  localparam logic [15:0] U_RPAREN = 16'h0029;

  typedef enum logic [2:0] {
    BODY_UNIT,
    BODY_LF,
    BODY_CR,
    BODY_LS,
    BODY_PS,
    BODY_EMPTY
  } body_t;

  typedef struct packed {
    logic        lead_bs;
    body_t       body;
    logic [15:0] code_unit;
    logic        src_end;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic logic [2:0] body_len(input body_t body);
    logic [2:0] len;
    case (body)
      BODY_LS:    len = 3'd5;
      BODY_PS:    len = 3'd5;
      BODY_EMPTY: len = 3'd4;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] body_unit(input body_t body, input logic [2:0] pos,
                                            input logic [15:0] code);
    logic [15:0] u;
    u = code;
    case (body)
      BODY_LF: u = U_N;
      BODY_CR: u = U_R;
      BODY_LS, BODY_PS: begin
        case (pos)
          3'd0:    u = U_U;
          3'd1:    u = U_TWO;
          3'd2:    u = U_ZERO;
          3'd3:    u = U_TWO;
          default: u = (body == BODY_LS) ? U_EIGHT : U_NINE;
        endcase
      end
      BODY_EMPTY: begin
        case (pos)
          3'd0:    u = U_LPAREN;
          3'd1:    u = U_QMARK;
          3'd2:    u = U_COLON;
          default: u = U_RPAREN;
        endcase
      end
      default: u = code;
    endcase
    return u;
  endfunction

endpackage

/* rtl/rse_front.sv */
// Front end: accepts pattern units, tracks escape and bracket state, classifies units.
module rse_front
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic after_bs_r, after_bs_nxt;
  logic in_brk_r, in_brk_nxt;
  logic slash_esc;
  logic line_term;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    slash_esc = !after_bs_r && !in_brk_r && (in_tdata == U_SLASH);
    line_term = (in_tdata == U_LF) || (in_tdata == U_CR) ||
                (in_tdata == U_LS) || (in_tdata == U_PS);
    q_entry.code_unit = in_tdata;
    q_entry.src_end   = in_tlast || in_tuser;
    after_bs_nxt      = after_bs_r;
    in_brk_nxt        = in_brk_r;
    if (in_tuser) begin
      q_entry.lead_bs = 1'b0;
      q_entry.body    = BODY_EMPTY;
    end else begin
      q_entry.lead_bs = slash_esc || (line_term && !after_bs_r);
      if (in_tdata == U_LF) begin
        q_entry.body = BODY_LF;
      end else if (in_tdata == U_CR) begin
        q_entry.body = BODY_CR;
      end else if (in_tdata == U_LS) begin
        q_entry.body = BODY_LS;
      end else if (in_tdata == U_PS) begin
        q_entry.body = BODY_PS;
      end else begin
        q_entry.body = BODY_UNIT;
      end
      if (!after_bs_r) begin
        if (in_brk_r) begin
          in_brk_nxt = (in_tdata != U_RBRACK);
        end else begin
          in_brk_nxt = (in_tdata == U_LBRACK);
        end
      end
      after_bs_nxt = !after_bs_r && (in_tdata == U_BSLASH);
    end
    if (in_tlast || in_tuser) begin
      after_bs_nxt = 1'b0;
      in_brk_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_bs_r <= 1'b0;
      in_brk_r   <= 1'b0;
    end else if (q_push) begin
      after_bs_r <= after_bs_nxt;
      in_brk_r   <= in_brk_nxt;
    end
  end

endmodule

/* rtl/rse_queue.sv */
// Short register queue of classified units between front and back ends.
`include "regex_source_escaper_defines.svh"
module rse_queue
  import rse_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  `RSE_ASSERT(a_no_overflow, clk, rst_n, !(push && full), "push into a full queue")
  `RSE_ASSERT(a_no_underflow, clk, rst_n, !(pop && !head.valid), "pop from an empty queue")
  `RSE_ASSERT(a_count_range, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count out of range")

endmodule

/* rtl/rse_back.sv */
// Back end: expands each classified unit into its output units through an output register.
`include "regex_source_escaper_defines.svh"
module rse_back
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  head_t       head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic [15:0] unit_r, unit_nxt;
  logic        last_r, last_nxt;
  logic        src_r, src_nxt;
  logic        load;
  logic        lead_now;
  logic [2:0]  body_pos;

  assign load       = head.valid && (!valid_r || out_tready);
  assign pop        = load && last_nxt;
  assign out_tvalid = valid_r;
  assign out_tdata  = unit_r;
  assign out_tlast  = last_r;
  assign out_tuser  = src_r;

  always_comb begin
    lead_now = head.entry.lead_bs && (idx_r == 3'd0);
    body_pos = idx_r - {2'b00, head.entry.lead_bs};
    if (lead_now) begin
      unit_nxt = U_BSLASH;
      last_nxt = 1'b0;
    end else begin
      unit_nxt = body_unit(head.entry.body, body_pos, head.entry.code_unit);
      last_nxt = (body_pos == body_len(head.entry.body) - 3'd1);
    end
    src_nxt = last_nxt && head.entry.src_end;
    idx_nxt = last_nxt ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= unit_nxt;
      last_r <= last_nxt;
      src_r  <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  `RSE_ASSERT(a_src_end_is_last, clk, rst_n, valid_r && src_r |-> last_r, "source end without run end")
  `RSE_ASSERT(a_idx_has_head, clk, rst_n, idx_r != 3'd0 |-> head.valid, "expansion in progress without a queued unit")
  `RSE_ASSERT(a_idx_range, clk, rst_n, idx_r < 3'd6, "expansion index out of range")

endmodule

/* rtl/regex_source_escaper.sv */
// The first output unit of an input transfer is presented from the output register; the
// input unit passes through the queue register before the back end loads it there.
// Throughput: one output unit per cycle while out_tready is high; an input unit that expands
// to n output units holds the back-end expander until all n are loaded, and plain units flow one per cycle.
// The queue between front and back ends absorbs bursts of expansions up to its depth.
// Reset is synchronous and active low; it clears the escape and bracket flags, the queue,
// and the output valid flag and expansion index.
module regex_source_escaper
  import rse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code_unit
  input  logic        in_tlast,
  input  logic        in_tuser,   // pattern_empty
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_unit
  output logic        out_tlast,
  output logic        out_tuser   // source_end
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  entry_t q_entry;
  head_t  q_head;

  rse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  rse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  rse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
